// ===== rtl/dcc_pf_pkg.sv =====
// ============================================================================
// DCC packet former package
// Command and packet byte types, action codes and fixed packet constants.
// ============================================================================
package dcc_pf_pkg;

  // Command kinds.
  localparam logic [2:0] ACT_LOCO_SPEED = 3'd0;
  localparam logic [2:0] ACT_ACCESSORY  = 3'd1;
  localparam logic [2:0] ACT_IDLE       = 3'd2;
  localparam logic [2:0] ACT_RESET      = 3'd3;
  localparam logic [2:0] ACT_CV_WRITE   = 3'd4;

  // Fixed bytes and masks of the packet formats.
  localparam logic [7:0] CV_WRITE_HEAD  = 8'b0111_1100;
  localparam logic [7:0] SPEED_128_INST = 8'h3f;
  localparam logic [7:0] LONG_ADDR_HEAD = 8'hc0;
  localparam logic [7:0] ACC_HEAD       = 8'h80;
  localparam logic [7:0] ACC_ACTIVATE   = 8'h08;
  localparam logic [7:0] IDLE_BYTE      = 8'hff;

  // Longest packet: four data bytes and the check byte.
  localparam int unsigned MaxBytes = 5;
  localparam int unsigned CountW   = $clog2(MaxBytes + 1);
  localparam int unsigned IndexW   = $clog2(MaxBytes);

  typedef logic [CountW-1:0] count_t;
  typedef logic [IndexW-1:0] index_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [13:0] decoder_address;
    logic [7:0]  speed_byte;
    logic        straight;
    logic [10:0] cv_number;
    logic [7:0]  cv_value;
  } command_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } packet_t;

endpackage

// ===== rtl/dcc_packet_former_top.sv =====
// ============================================================================
// DCC packet former
// Turns one railway command into the bytes of one DCC packet, check last.
// ============================================================================
// The block delivers one packet byte per cycle while packet_stall is low. A
// command is held in an input register, formed in one pass into a packet
// register of up to five bytes, and the packet is then sent in transmission
// order with last_byte set on the XOR check byte. A packet has three to five
// bytes; the next command is formed while the last byte of the previous
// packet leaves, so back-to-back commands give a gap-free byte stream and the
// single output byte port sets the command rate. A command that yields no
// bytes (a locomotive or accessory command with address zero, or an unknown
// action) waits in the input register until the packet register is free and
// is then dropped, which leaves a one-cycle gap in the byte stream. No
// preamble, bit timing or repetition is produced here.
module dcc_packet_former_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                command_valid,
  output logic                command_stall,
  input  dcc_pf_pkg::command_t command,
  output logic                packet_valid,
  input  logic                packet_stall,
  output dcc_pf_pkg::packet_t packet
);

  // Input register holding one accepted command.
  logic                 held_valid;
  dcc_pf_pkg::command_t held;

  // Packet register: formed bytes, byte count and send position.
  logic [7:0]          pkt_bytes [dcc_pf_pkg::MaxBytes];
  dcc_pf_pkg::count_t  pkt_count;
  dcc_pf_pkg::index_t  pkt_index;
  logic                pkt_valid;

  logic                out_take;
  logic                out_last;
  logic                held_take;

  // Formation of the held command.
  logic [7:0]          data [dcc_pf_pkg::MaxBytes];
  dcc_pf_pkg::count_t  data_count;
  logic [7:0]          check;
  logic [7:0]          form_bytes [dcc_pf_pkg::MaxBytes];
  dcc_pf_pkg::count_t  form_count;
  logic [13:0]         acc_n;
  logic [11:0]         acc_board;
  logic [9:0]          cv_index;

  assign out_last  = (dcc_pf_pkg::count_t'(pkt_index) ==
                      pkt_count - dcc_pf_pkg::count_t'(1));
  assign out_take  = pkt_valid && !packet_stall;

  // The packet register is free when empty or when its last byte leaves now.
  assign held_take = held_valid && (!pkt_valid || (out_take && out_last));

  // A command enters whenever the input register is empty or being emptied.
  assign command_stall = held_valid && !held_take;

  assign packet_valid       = pkt_valid;
  assign packet.packet_byte = pkt_bytes[pkt_index];
  assign packet.last_byte   = out_last;

  // Accessory addressing: decoder board and output channel from address - 1.
  assign acc_n     = held.decoder_address - 14'd1;
  assign acc_board = acc_n[13:2] + 12'd1;
  // CV numbers are one-based on the wire side, zero-based in the packet.
  assign cv_index  = held.cv_number[9:0] - 10'd1;

  always_comb begin
    for (int i = 0; i < dcc_pf_pkg::MaxBytes; i++) begin
      data[i] = 8'h00;
    end
    data_count = '0;
    case (held.action)
      dcc_pf_pkg::ACT_LOCO_SPEED: begin
        if (held.decoder_address == 14'd0) begin
          data_count = '0;
        end else if (held.decoder_address < 14'd128) begin
          data[0]    = held.decoder_address[7:0];
          data[1]    = dcc_pf_pkg::SPEED_128_INST;
          data[2]    = held.speed_byte;
          data_count = dcc_pf_pkg::count_t'(3);
        end else begin
          data[0]    = dcc_pf_pkg::LONG_ADDR_HEAD | {2'b00, held.decoder_address[13:8]};
          data[1]    = held.decoder_address[7:0];
          data[2]    = dcc_pf_pkg::SPEED_128_INST;
          data[3]    = held.speed_byte;
          data_count = dcc_pf_pkg::count_t'(4);
        end
      end
      dcc_pf_pkg::ACT_ACCESSORY: begin
        if (held.decoder_address != 14'd0) begin
          data[0]    = dcc_pf_pkg::ACC_HEAD | {2'b00, acc_board[5:0]};
          data[1]    = dcc_pf_pkg::ACC_HEAD | {1'b0, ~acc_board[8:6], 4'b0000} |
                       dcc_pf_pkg::ACC_ACTIVATE | {5'b00000, acc_n[1:0], held.straight};
          data_count = dcc_pf_pkg::count_t'(2);
        end
      end
      dcc_pf_pkg::ACT_IDLE: begin
        data[0]    = dcc_pf_pkg::IDLE_BYTE;
        data_count = dcc_pf_pkg::count_t'(2);
      end
      dcc_pf_pkg::ACT_RESET: begin
        data_count = dcc_pf_pkg::count_t'(2);
      end
      dcc_pf_pkg::ACT_CV_WRITE: begin
        data[0]    = dcc_pf_pkg::CV_WRITE_HEAD | {6'b000000, cv_index[9:8]};
        data[1]    = cv_index[7:0];
        data[2]    = held.cv_value;
        data_count = dcc_pf_pkg::count_t'(3);
      end
      default: begin
        data_count = '0;
      end
    endcase

    // Unused data slots are zero, so the check byte is the XOR of all slots.
    check = data[0] ^ data[1] ^ data[2] ^ data[3] ^ data[4];

    // The check byte follows the data bytes; a packet with no data is empty.
    for (int i = 0; i < dcc_pf_pkg::MaxBytes; i++) begin
      if (dcc_pf_pkg::count_t'(i) < data_count) begin
        form_bytes[i] = data[i];
      end else if (dcc_pf_pkg::count_t'(i) == data_count) begin
        form_bytes[i] = check;
      end else begin
        form_bytes[i] = 8'h00;
      end
    end
    form_count = (data_count == '0) ? '0 : data_count + dcc_pf_pkg::count_t'(1);
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!command_stall) begin
      held_valid <= command_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (command_valid && !command_stall) begin
      held <= command;
    end
  end

  // Packet register and send position.
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
      pkt_index <= '0;
    end else if (held_take) begin
      pkt_valid <= (form_count != '0);
      pkt_index <= '0;
    end else if (out_take) begin
      if (out_last) begin
        pkt_valid <= 1'b0;
        pkt_index <= '0;
      end else begin
        pkt_index <= pkt_index + dcc_pf_pkg::index_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (held_take) begin
      pkt_bytes <= form_bytes;
      pkt_count <= form_count;
    end
  end

`ifndef SYNTHESIS
  // A packet being sent has at least three bytes and a position inside it.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    pkt_valid |-> (pkt_count >= dcc_pf_pkg::count_t'(3)) &&
                  (dcc_pf_pkg::count_t'(pkt_index) < pkt_count))
    else $error("packet count or position out of range");

  // A byte other than the last leaves; the next byte of the same packet follows.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (out_take && !out_last && !held_take) |=>
      pkt_valid && (pkt_index == $past(pkt_index) + dcc_pf_pkg::index_t'(1)))
    else $error("packet position did not advance");

  // An accepted command always lands in the input register.
  a_capture: assert property (@(posedge clk) disable iff (rst)
    (command_valid && !command_stall) |=> held_valid)
    else $error("accepted command not held");

  // The packet register is never overwritten while a byte is still pending.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (held_take && pkt_valid) |-> (out_take && out_last))
    else $error("packet overwritten before its last byte left");
`endif

endmodule

// ===== tb/testbench.sv =====
// ============================================================================
// DCC packet former testbench
// Sends directed and random railway commands into the packet former and
// compares every packet byte and last-byte flag against a built-in predictor,
// while both handshakes idle and stall at random.
// ============================================================================
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 command_valid;
  logic                 command_stall;
  dcc_pf_pkg::command_t command;
  logic                 packet_valid;
  logic                 packet_stall;
  dcc_pf_pkg::packet_t  packet;

  // Packet bytes still owed by the block, oldest first.
  dcc_pf_pkg::packet_t expected_bytes[$];
  int unsigned error_count = 0;

  // While steady is set neither side idles, so requests and bytes flow
  // back to back.
  bit steady;

  dcc_packet_former_top dut (
    .clk           (clk),
    .rst           (rst),
    .command_valid (command_valid),
    .command_stall (command_stall),
    .command       (command),
    .packet_valid  (packet_valid),
    .packet_stall  (packet_stall),
    .packet        (packet)
  );

  always #5 clk = ~clk;

  // Absolute limit on the run; a correct run needs a small fraction of it.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // The receiver stalls in roughly one cycle of five unless steady is set.
  always @(posedge clk) begin
    packet_stall <= !steady && ($urandom_range(0, 99) < 19);
  end

  // Forms the bytes of the packet that one command should produce and queues
  // them.  Commands that produce nothing (zero address on a locomotive or
  // accessory, or an unknown action) queue nothing.
  task automatic predict_packet(input dcc_pf_pkg::command_t c);
    logic [7:0]  body [4];
    int unsigned nbytes;
    logic [7:0]  check;
    logic [31:0] addr;
    logic [31:0] idx;
    logic [31:0] board;
    logic [31:0] board_inv;
    logic [31:0] cv_index;
    dcc_pf_pkg::packet_t p;
    nbytes = 0;
    addr   = 32'(c.decoder_address);
    case (c.action)
      dcc_pf_pkg::ACT_LOCO_SPEED: begin
        if (addr != 0) begin
          if (addr < 128) begin
            body[0] = addr[7:0];
            body[1] = dcc_pf_pkg::SPEED_128_INST;
            body[2] = c.speed_byte;
            nbytes  = 3;
          end else begin
            // Long address: top six address bits behind the 11 marker.
            body[0] = dcc_pf_pkg::LONG_ADDR_HEAD | {2'b00, addr[13:8]};
            body[1] = addr[7:0];
            body[2] = dcc_pf_pkg::SPEED_128_INST;
            body[3] = c.speed_byte;
            nbytes  = 4;
          end
        end
      end
      dcc_pf_pkg::ACT_ACCESSORY: begin
        if (addr != 0) begin
          // Four outputs per board; the high board bits go out inverted.
          idx       = addr - 1;
          board     = (idx >> 2) + 1;
          board_inv = ~board >> 6;
          body[0]   = dcc_pf_pkg::ACC_HEAD | {2'b00, board[5:0]};
          body[1]   = dcc_pf_pkg::ACC_HEAD | {1'b0, board_inv[2:0], 4'b0000} |
                      dcc_pf_pkg::ACC_ACTIVATE | {5'b00000, idx[1:0], c.straight};
          nbytes    = 2;
        end
      end
      dcc_pf_pkg::ACT_IDLE: begin
        body[0] = dcc_pf_pkg::IDLE_BYTE;
        body[1] = 8'h00;
        nbytes  = 2;
      end
      dcc_pf_pkg::ACT_RESET: begin
        body[0] = 8'h00;
        body[1] = 8'h00;
        nbytes  = 2;
      end
      dcc_pf_pkg::ACT_CV_WRITE: begin
        // CV numbers count from one; zero and values past 1024 wrap.
        cv_index = (32'(c.cv_number) - 32'd1) & 32'h3ff;
        body[0]  = dcc_pf_pkg::CV_WRITE_HEAD | {6'b000000, cv_index[9:8]};
        body[1]  = cv_index[7:0];
        body[2]  = c.cv_value;
        nbytes   = 3;
      end
      default: ;
    endcase
    if (nbytes != 0) begin
      check = 8'h00;
      for (int i = 0; i < nbytes; i++) begin
        p.packet_byte = body[i];
        p.last_byte   = 1'b0;
        expected_bytes.push_back(p);
        check ^= body[i];
      end
      p.packet_byte = check;
      p.last_byte   = 1'b1;
      expected_bytes.push_back(p);
    end
  endtask

  // Every accepted byte is matched against the oldest expectation.  Inputs
  // are read at the edge itself, so they hold the values the block saw.
  always @(posedge clk) begin : check_packets
    dcc_pf_pkg::packet_t want;
    if (!rst && packet_valid && !packet_stall) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected packet byte %02h last %0b", $time,
                 packet.packet_byte, packet.last_byte);
        error_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (packet.packet_byte !== want.packet_byte) begin
          $display("%0t: packet_byte expected %02h actual %02h", $time,
                   want.packet_byte, packet.packet_byte);
          error_count++;
        end
        if (packet.last_byte !== want.last_byte) begin
          $display("%0t: last_byte expected %0b actual %0b", $time,
                   want.last_byte, packet.last_byte);
          error_count++;
        end
      end
    end
  end

  // Sends one request.  Entered and left right after a rising edge.  The
  // valid stays high on return so a following request can go out in the
  // very next cycle; only an idle gap or a drain lowers it.
  task automatic send_command(input dcc_pf_pkg::command_t c);
    while (!steady && ($urandom_range(0, 99) < 19)) begin
      command_valid <= 1'b0;
      @(posedge clk);
    end
    command_valid <= 1'b1;
    command       <= c;
    do @(posedge clk); while (command_stall);
    predict_packet(c);
  endtask

  // The sender holds off until the block has delivered every owed byte.
  task automatic wait_for_drain();
    command_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic dcc_pf_pkg::command_t make_command(input logic [2:0] action,
                                                        input logic [13:0] addr,
                                                        input logic [7:0] speed,
                                                        input logic straight,
                                                        input logic [10:0] cv_num,
                                                        input logic [7:0] cv_val);
    dcc_pf_pkg::command_t c;
    c.action          = action;
    c.decoder_address = addr;
    c.speed_byte      = speed;
    c.straight        = straight;
    c.cv_number       = cv_num;
    c.cv_value        = cv_val;
    return c;
  endfunction

  // Mostly well-formed commands with random content; a few unknown actions,
  // zero addresses and out-of-range CV numbers mixed in.
  function automatic dcc_pf_pkg::command_t random_command();
    logic [2:0] kinds [5];
    dcc_pf_pkg::command_t c;
    int unsigned sel;
    kinds = '{dcc_pf_pkg::ACT_LOCO_SPEED, dcc_pf_pkg::ACT_ACCESSORY,
              dcc_pf_pkg::ACT_IDLE, dcc_pf_pkg::ACT_RESET, dcc_pf_pkg::ACT_CV_WRITE};
    c.action          = kinds[$urandom_range(0, 4)];
    c.decoder_address = 14'($urandom);
    c.speed_byte      = 8'($urandom);
    c.straight        = 1'($urandom);
    c.cv_number       = 11'($urandom_range(1, 1024));
    c.cv_value        = 8'($urandom);
    if ($urandom_range(0, 99) < 7) begin
      c.action = 3'($urandom_range(int'(dcc_pf_pkg::ACT_CV_WRITE) + 1, 7));
    end
    if ($urandom_range(0, 99) < 15) begin
      c.cv_number = 11'($urandom);
    end
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      c.decoder_address = '0;
    end else if (sel < 5) begin
      c.decoder_address = 14'($urandom_range(1, 127));
    end else if (sel == 5) begin
      c.decoder_address = 14'($urandom_range(128, 255));
    end
    return c;
  endfunction

  task automatic test_loco_short();
    send_command(make_command(dcc_pf_pkg::ACT_LOCO_SPEED, 14'd1, 8'h00, 1'b0,
                              11'd1, 8'h00));
    send_command(make_command(dcc_pf_pkg::ACT_LOCO_SPEED, 14'd127, 8'hff, 1'b1,
                              11'd1, 8'h00));
    send_command(make_command(dcc_pf_pkg::ACT_LOCO_SPEED, 14'd3, 8'h80, 1'b0,
                              11'd1, 8'h00));
  endtask

  task automatic test_loco_long();
    send_command(make_command(dcc_pf_pkg::ACT_LOCO_SPEED, 14'd128, 8'h7f, 1'b0,
                              11'd1, 8'h00));
    send_command(make_command(dcc_pf_pkg::ACT_LOCO_SPEED, 14'h3fff, 8'hff, 1'b0,
                              11'd1, 8'h00));
    send_command(make_command(dcc_pf_pkg::ACT_LOCO_SPEED, 14'h2a5a, 8'h01, 1'b0,
                              11'd1, 8'h00));
  endtask

  // Board boundaries and the inverted high board bits.
  task automatic test_accessory();
    send_command(make_command(dcc_pf_pkg::ACT_ACCESSORY, 14'd1, 8'h00, 1'b1,
                              11'd1, 8'h00));
    send_command(make_command(dcc_pf_pkg::ACT_ACCESSORY, 14'd4, 8'h00, 1'b0,
                              11'd1, 8'h00));
    send_command(make_command(dcc_pf_pkg::ACT_ACCESSORY, 14'd5, 8'h00, 1'b1,
                              11'd1, 8'h00));
    send_command(make_command(dcc_pf_pkg::ACT_ACCESSORY, 14'd256, 8'h00, 1'b0,
                              11'd1, 8'h00));
    send_command(make_command(dcc_pf_pkg::ACT_ACCESSORY, 14'h3fff, 8'hff, 1'b1,
                              11'd1, 8'h00));
  endtask

  task automatic test_idle_and_reset();
    send_command(make_command(dcc_pf_pkg::ACT_IDLE, 14'h3fff, 8'hff, 1'b1,
                              11'h7ff, 8'hff));
    send_command(make_command(dcc_pf_pkg::ACT_RESET, 14'd0, 8'h00, 1'b0,
                              11'd0, 8'h00));
  endtask

  // CV 1 and 1024, plus the wrap of zero and of numbers past 1024.
  task automatic test_cv_write();
    send_command(make_command(dcc_pf_pkg::ACT_CV_WRITE, 14'd0, 8'h00, 1'b0,
                              11'd1, 8'h00));
    send_command(make_command(dcc_pf_pkg::ACT_CV_WRITE, 14'd0, 8'h00, 1'b0,
                              11'd1024, 8'hff));
    send_command(make_command(dcc_pf_pkg::ACT_CV_WRITE, 14'd0, 8'h00, 1'b0,
                              11'd0, 8'ha5));
    send_command(make_command(dcc_pf_pkg::ACT_CV_WRITE, 14'd0, 8'h00, 1'b0,
                              11'd1025, 8'h5a));
    send_command(make_command(dcc_pf_pkg::ACT_CV_WRITE, 14'd0, 8'h00, 1'b0,
                              11'h7ff, 8'h3c));
  endtask

  // Zero addresses and unknown actions give no bytes at all.
  task automatic test_skipped_commands();
    send_command(make_command(dcc_pf_pkg::ACT_LOCO_SPEED, 14'd0, 8'hff, 1'b1,
                              11'd1, 8'hff));
    send_command(make_command(dcc_pf_pkg::ACT_ACCESSORY, 14'd0, 8'hff, 1'b1,
                              11'd1, 8'hff));
    send_command(make_command(3'(int'(dcc_pf_pkg::ACT_CV_WRITE) + 1), 14'd5, 8'h10,
                              1'b0, 11'd2, 8'h01));
    send_command(make_command(3'(int'(dcc_pf_pkg::ACT_CV_WRITE) + 2), 14'd200, 8'h10,
                              1'b1, 11'd2, 8'h01));
    send_command(make_command(3'h7, 14'h3fff, 8'hff, 1'b1, 11'h7ff, 8'hff));
    // A known packet right behind the skipped ones must still come out.
    send_command(make_command(dcc_pf_pkg::ACT_IDLE, 14'd0, 8'h00, 1'b0,
                              11'd1, 8'h00));
  endtask

  // No idling on either side: the byte stream runs without gaps except where a command yields no bytes.
  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (80) send_command(random_command());
    steady = 1'b0;
  endtask

  // Random traffic with idling; halfway through the sender lets the block
  // drain completely before going on.
  task automatic test_random_traffic();
    repeat (140) send_command(random_command());
    wait_for_drain();
    repeat (140) send_command(random_command());
  endtask

  initial begin
    steady        = 1'b0;
    rst           <= 1'b1;
    command_valid <= 1'b0;
    command       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_loco_short();
    test_loco_long();
    test_accessory();
    test_idle_and_reset();
    test_cv_write();
    test_skipped_commands();
    test_back_to_back();
    test_random_traffic();

    // Let the last packet leave, then allow for a dropped command still in
    // the input register before looking for stray bytes.
    wait_for_drain();
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dcc_pf_pkg.sv
rtl/dcc_packet_former_top.sv
tb/testbench.sv
